// ===== design/move_to_front_recent_list_unit_assert.svh =====
// Assertion macros shared by the checker of the recent list unit.
// Both expect a clock named clk and an active-high reset named rst in scope.
`ifndef MOVE_TO_FRONT_RECENT_LIST_UNIT_ASSERT_SVH
`define MOVE_TO_FRONT_RECENT_LIST_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MTF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mtf_pkg.sv =====
package mtf_pkg;

  localparam int KEY_FIELD_W       = 64;
  localparam int OP_W              = 3;
  localparam int IDX_W             = 4;
  localparam int CNT_W             = 4;
  localparam int IN_TDATA_W        = 72;
  localparam int OUT_TDATA_W       = 72;
  localparam int DEPTH_DEFAULT     = 8;
  localparam int KEY_WIDTH_DEFAULT = 64;

  typedef enum logic [OP_W-1:0] {
    OP_NOTE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_READ  = 3'd2,
    OP_RESET = 3'd3,
    OP_CLEAR = 3'd4,
    OP_SAVE  = 3'd5
  } op_t;

  // Read address source of the entry memory.
  typedef enum logic [1:0] {
    RA_SEARCH,
    RA_SHIFT,
    RA_INDEX
  } rd_addr_t;

  typedef struct packed {
    logic     capture;   // take a new item into the working registers
    logic     rd_en;     // read the entry memory
    rd_addr_t rd_sel;
    logic     step;      // compare read entry with key, advance on miss
    logic     set_last;  // aim the shift pointer at the slot to vacate
    logic     shift_wr;  // move read entry one slot down, step pointer back
    logic     front_wr;  // write key at the front
    logic     load_wr;   // append key at the end
    logic     finish;    // apply simple ops and load the result register
  } mtf_cmd_t;

  typedef struct packed {
    op_t  op;
    logic key_zero;
    logic search_done;
    logic match;
    logic found;
    logic ptr_zero;
    logic full;
    logic out_free;
  } mtf_status_t;

endpackage

// ===== design/mtf_ctrl.sv =====
module mtf_ctrl
  import mtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  mtf_status_t status,
  output mtf_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_PLACE,
    ST_SHIFT_CHK,
    ST_SHIFT_WR,
    ST_FRONT_WR,
    ST_LOAD_WR,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RA_SEARCH;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if ((status.op == OP_NOTE || status.op == OP_LOAD) && !status.key_zero) begin
          state_next = ST_SRCH_RD;
        end else if (status.op == OP_READ) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_INDEX;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SRCH_RD: begin
        if (status.search_done) begin
          state_next = ST_PLACE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_SEARCH;
          state_next = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        cmd.step   = 1'b1;
        state_next = status.match ? ST_PLACE : ST_SRCH_RD;
      end
      ST_PLACE: begin
        if (status.op == OP_LOAD) begin
          state_next = (status.found || status.full) ? ST_FINISH : ST_LOAD_WR;
        end else if (status.found && status.ptr_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.set_last = 1'b1;
          state_next   = ST_SHIFT_CHK;
        end
      end
      ST_SHIFT_CHK: begin
        if (status.ptr_zero) begin
          state_next = ST_FRONT_WR;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_SHIFT;
          state_next = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = ST_SHIFT_CHK;
      end
      ST_FRONT_WR: begin
        cmd.front_wr = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_LOAD_WR: begin
        cmd.load_wr = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/mtf_datapath.sv =====
module mtf_datapath
  import mtf_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mtf_cmd_t               cmd,
  output mtf_status_t            status,
  input  logic [OP_W-1:0]        operation,
  input  logic [KEY_FIELD_W-1:0] entry_key,
  input  logic [IDX_W-1:0]       read_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KEY_FIELD_W-1:0] read_key,
  output logic                   read_valid,
  output logic [CNT_W-1:0]       list_count,
  output logic                   dirty_out
);

  localparam int AW = $clog2(DEPTH);

  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic [KEY_WIDTH-1:0] rd_data;
  logic [KEY_WIDTH-1:0] key_q;
  op_t                  op_q;
  logic [IDX_W-1:0]     idx_q;
  logic [CNT_W-1:0]     ptr;
  logic                 found;
  logic [CNT_W-1:0]     count;
  logic                 dirty;

  logic [CNT_W-1:0]       ptr_inc;
  logic [CNT_W-1:0]       ptr_dec;
  logic [CNT_W-1:0]       count_inc;
  logic [CNT_W-1:0]       last_slot;
  logic                   full;
  logic                   match;
  logic                   rd_hit;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [KEY_WIDTH-1:0]   wr_data;
  logic [CNT_W-1:0]       count_fin;
  logic                   dirty_fin;
  logic [KEY_FIELD_W-1:0] key_fin;
  logic                   valid_fin;

  assign ptr_inc   = ptr + CNT_W'(1);
  assign ptr_dec   = ptr - CNT_W'(1);
  assign count_inc = count + CNT_W'(1);
  assign full      = (count >= CNT_W'(DEPTH));
  assign last_slot = full ? CNT_W'(DEPTH - 1) : count;
  assign match     = (rd_data == key_q);
  assign rd_hit    = (idx_q < count);

  assign status.op          = op_q;
  assign status.key_zero    = (key_q == '0);
  assign status.search_done = (ptr >= count);
  assign status.match       = match;
  assign status.found       = found;
  assign status.ptr_zero    = (ptr == '0);
  assign status.full        = full;
  assign status.out_free    = !out_valid || out_ready;

  always_comb begin
    case (cmd.rd_sel)
      RA_SEARCH: rd_addr = ptr[AW-1:0];
      RA_SHIFT:  rd_addr = ptr_dec[AW-1:0];
      RA_INDEX:  rd_addr = idx_q[AW-1:0];
      default:   rd_addr = ptr[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = cmd.shift_wr || cmd.front_wr || cmd.load_wr;
    wr_addr = '0;
    wr_data = key_q;
    if (cmd.shift_wr) begin
      wr_addr = ptr[AW-1:0];
      wr_data = rd_data;
    end else if (cmd.load_wr) begin
      wr_addr = count[AW-1:0];
    end
  end

  always_comb begin
    count_fin = count;
    dirty_fin = dirty;
    key_fin   = '0;
    valid_fin = 1'b0;
    case (op_q)
      OP_READ: begin
        if (rd_hit) begin
          key_fin[KEY_WIDTH-1:0] = rd_data;
          valid_fin              = 1'b1;
        end
      end
      OP_RESET: begin
        count_fin = '0;
        dirty_fin = 1'b0;
      end
      OP_CLEAR: begin
        count_fin = '0;
        dirty_fin = 1'b1;
      end
      OP_SAVE: begin
        dirty_fin = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      found     <= 1'b0;
      count     <= '0;
      dirty     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        ptr   <= '0;
        found <= 1'b0;
      end
      if (cmd.step) begin
        if (match) begin
          found <= 1'b1;
        end else begin
          ptr <= ptr_inc;
        end
      end
      if (cmd.set_last && !found) begin
        ptr <= last_slot;
      end
      if (cmd.shift_wr) begin
        ptr <= ptr_dec;
      end
      if (cmd.front_wr) begin
        dirty <= 1'b1;
        if (!found && !full) begin
          count <= count_inc;
        end
      end
      if (cmd.load_wr) begin
        count <= count_inc;
      end
      if (cmd.finish) begin
        count     <= count_fin;
        dirty     <= dirty_fin;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op_t'(operation);
      key_q <= entry_key[KEY_WIDTH-1:0];
      idx_q <= read_index;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.finish) begin
      read_key   <= key_fin;
      read_valid <= valid_fin;
      list_count <= count_fin;
      dirty_out  <= dirty_fin;
    end
  end

endmodule

// ===== design/move_to_front_recent_list_unit.sv =====
// Throughput: one item at a time; the next item is taken once the current one
//   reaches the result register. The single-port entry memory sets the pace.
// Reset: synchronous, active high; clears count, dirty flag and handshakes.
//   Entry storage is not cleared; only positions below count are ever used.
module move_to_front_recent_list_unit
  import mtf_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEFAULT,     // list slots, 2 to 15
  parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT  // significant key bits, 8 to 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // entry_key [63:0], read_index [67:64], zero pad [71:68]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation [2:0]
  input  logic [OP_W-1:0]        s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // read_key [63:0], list_count [67:64], dirty_out [68], zero pad [71:69]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // read_valid [0]
  output logic [0:0]             m_axis_tuser
);

  mtf_cmd_t    cmd;
  mtf_status_t status;

  logic [KEY_FIELD_W-1:0] read_key;
  logic                   read_valid;
  logic [CNT_W-1:0]       list_count;
  logic                   dirty_out;

  // Sequencer: walks the search, shift and write steps of each item.
  mtf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Entry memory, count, dirty flag and the result register.
  mtf_datapath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .operation  (s_axis_tuser),
    .entry_key  (s_axis_tdata[KEY_FIELD_W-1:0]),
    .read_index (s_axis_tdata[KEY_FIELD_W+IDX_W-1:KEY_FIELD_W]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .read_key   (read_key),
    .read_valid (read_valid),
    .list_count (list_count),
    .dirty_out  (dirty_out)
  );

  // Pack the result item; pad bits stay zero.
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[KEY_FIELD_W-1:0]                   = read_key;
    m_axis_tdata[KEY_FIELD_W+CNT_W-1:KEY_FIELD_W]   = list_count;
    m_axis_tdata[KEY_FIELD_W+CNT_W]                 = dirty_out;
    m_axis_tuser[0]                                 = read_valid;
  end

endmodule

// ===== design/mtf_checker.sv =====
`include "move_to_front_recent_list_unit_assert.svh"

module mtf_checker
  import mtf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]             m_axis_tuser
);

  `MTF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item accepted while previous one still in work")
  `MTF_ASSERT_NOW(a_count_bounded, m_axis_tvalid, m_axis_tdata[KEY_FIELD_W+CNT_W-1:KEY_FIELD_W] <= CNT_W'(DEPTH), "list count above depth")
  `MTF_ASSERT_NOW(a_miss_key_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[KEY_FIELD_W-1:0] == '0, "nonzero key on result without a read hit")
  `MTF_ASSERT_NEXT(a_result_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind move_to_front_recent_list_unit mtf_checker #(.DEPTH(DEPTH)) u_mtf_checker (.*);
